[rtl/lqe_pkg.sv]
// shared constants and types for the line to quad expansion unit
`default_nettype none
package lqe_pkg;

   // magnitudes are brought below this many bits before squaring
   localparam int LIM_BITS  = 24;
   // extra fraction bits on the squared length before the root
   localparam int SQ_SHIFT  = 14;
   // line width field
   localparam int W_BITS    = 12;
   // offset magnitude never exceeds ceil(w/2), so it fits this many bits
   localparam int Q_BITS    = 12;
   // dividend scale, undoes the 7 root fraction bits and the halving
   localparam int RND_SHIFT = 6;

   typedef struct packed {
      logic degen;
      logic neg_dx;
      logic neg_dy;
   } seg_flags_type;

endpackage
`default_nettype wire

[rtl/line_to_quad_expansion_unit.sv]
// R = root width (24 at COORD_BITS 16); depth comes from the front stages, the square root,
// which resolves one root bit per stage, 13 divider stages and the corner and output registers
// throughput: one segment per cycle while req_stall is low, one result per segment
// a stalled result parks in a skid register; input stalls only while that register is full
// reset clears all valid bits and the output/skid flags; data registers are not reset
`default_nettype none
module line_to_quad_expansion_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_BITS-1:0]   req_start_x,
   input  logic signed [COORD_BITS-1:0]   req_start_y,
   input  logic signed [COORD_BITS-1:0]   req_end_x,
   input  logic signed [COORD_BITS-1:0]   req_end_y,
   input  logic [lqe_pkg::W_BITS-1:0]     req_line_width,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [COORD_BITS-1:0]   rsp_corner0_x,
   output logic signed [COORD_BITS-1:0]   rsp_corner0_y,
   output logic signed [COORD_BITS-1:0]   rsp_corner1_x,
   output logic signed [COORD_BITS-1:0]   rsp_corner1_y,
   output logic signed [COORD_BITS-1:0]   rsp_corner2_x,
   output logic signed [COORD_BITS-1:0]   rsp_corner2_y,
   output logic signed [COORD_BITS-1:0]   rsp_corner3_x,
   output logic signed [COORD_BITS-1:0]   rsp_corner3_y,
   output logic                           rsp_degenerate
);
   import lqe_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int MW   = (CW > LIM_BITS) ? LIM_BITS : CW;
   localparam int SUMW = 2 * MW + 1 + SQ_SHIFT;
   localparam int NW   = SUMW + (SUMW % 2);
   localparam int R    = NW / 2;
   localparam int PW   = MW + W_BITS;
   localparam int FLW  = $bits(seg_flags_type);
   localparam int TW2  = FLW + 4 * CW;
   localparam int TW1  = TW2 + 2 * PW;
   localparam int SW   = ((CW > Q_BITS + 1) ? CW : Q_BITS + 1) + 1;
   localparam int RSW  = 8 * CW + 1;
   localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] CMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   function automatic logic [CW-1:0] sat_add(input logic signed [CW-1:0] p,
                                             input logic signed [Q_BITS:0] d,
                                             input logic sub);
      logic signed [SW-1:0] s;
      s = sub ? (SW'(p) - SW'(d)) : (SW'(p) + SW'(d));
      if (s > CMAX) begin
         s = CMAX;
      end else if (s < CMIN) begin
         s = CMIN;
      end
      return s[CW-1:0];
   endfunction

   logic                 en;
   logic                 fr_valid;
   logic [NW-1:0]        fr_sum;
   logic [PW-1:0]        fr_aw;
   logic [PW-1:0]        fr_bw;
   seg_flags_type        fr_flags;
   logic [4*CW-1:0]      fr_pts;
   logic                 sq_valid;
   logic [R-1:0]         sq_root;
   logic [TW1-1:0]       sq_tag;
   logic                 dv_valid;
   logic [Q_BITS-1:0]    dv_qx;
   logic [Q_BITS-1:0]    dv_qy;
   logic [TW2-1:0]       dv_tag;
   seg_flags_type        dv_flags;
   logic signed [CW-1:0] c_sx;
   logic signed [CW-1:0] c_sy;
   logic signed [CW-1:0] c_ex;
   logic signed [CW-1:0] c_ey;
   logic signed [Q_BITS:0] xd;
   logic signed [Q_BITS:0] yd;
   logic [RSW-1:0]       e_res_in;
   logic [RSW-1:0]       e_res_ff;
   logic                 e_v_ff;
   logic                 inc;
   logic                 take;
   logic [RSW-1:0]       out_in;
   logic [RSW-1:0]       out_ff;
   logic                 out_v_in;
   logic                 out_v_ff;
   logic [RSW-1:0]       skid_in;
   logic [RSW-1:0]       skid_ff;
   logic                 skid_v_in;
   logic                 skid_v_ff;

   // whole pipeline moves together unless the skid register holds a result
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   lqe_front #(.CW(CW), .MW(MW), .NW(NW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .line_width (req_line_width),
      .out_valid  (fr_valid),
      .sq_sum     (fr_sum),
      .aw         (fr_aw),
      .bw         (fr_bw),
      .flags      (fr_flags),
      .pts        (fr_pts)
   );

   lqe_sqrt #(.NW(NW), .TW(TW1)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .radicand  (fr_sum),
      .in_tag    ({fr_flags, fr_pts, fr_aw, fr_bw}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_tag   (sq_tag)
   );

   // x offset scales with |dy|, y offset with |dx|
   lqe_div #(.PW(PW), .DVW(R), .TW(TW2)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .divisor   (sq_root),
      .prod_x    (sq_tag[PW-1:0]),
      .prod_y    (sq_tag[2*PW-1 -: PW]),
      .in_tag    (sq_tag[TW1-1 -: TW2]),
      .out_valid (dv_valid),
      .quot_x    (dv_qx),
      .quot_y    (dv_qy),
      .out_tag   (dv_tag)
   );

   always_comb begin
      dv_flags = seg_flags_type'(dv_tag[TW2-1 -: FLW]);
      c_sx     = dv_tag[4*CW-1 -: CW];
      c_sy     = dv_tag[3*CW-1 -: CW];
      c_ex     = dv_tag[2*CW-1 -: CW];
      c_ey     = dv_tag[CW-1:0];
      if (dv_flags.degen) begin
         xd = '0;
         yd = '0;
      end else begin
         xd = dv_flags.neg_dy ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
         yd = dv_flags.neg_dx ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
      end
      e_res_in = {sat_add(c_sx, xd, 1'b0), sat_add(c_sy, yd, 1'b1),
                  sat_add(c_sx, xd, 1'b1), sat_add(c_sy, yd, 1'b0),
                  sat_add(c_ex, xd, 1'b1), sat_add(c_ey, yd, 1'b0),
                  sat_add(c_ex, xd, 1'b0), sat_add(c_ey, yd, 1'b1),
                  dv_flags.degen};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en) begin
         e_v_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_res_ff <= e_res_in;
      end
   end

   assign inc  = en && e_v_ff;
   assign take = out_v_ff && !rsp_stall;

   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (take) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (inc) begin
         if (!out_v_ff || take) begin
            out_in   = e_res_ff;
            out_v_in = 1'b1;
         end else begin
            skid_in   = e_res_ff;
            skid_v_in = 1'b1;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_corner0_x  = out_ff[RSW-1 -: CW];
   assign rsp_corner0_y  = out_ff[RSW-1-CW -: CW];
   assign rsp_corner1_x  = out_ff[RSW-1-2*CW -: CW];
   assign rsp_corner1_y  = out_ff[RSW-1-3*CW -: CW];
   assign rsp_corner2_x  = out_ff[RSW-1-4*CW -: CW];
   assign rsp_corner2_y  = out_ff[RSW-1-5*CW -: CW];
   assign rsp_corner3_x  = out_ff[RSW-1-6*CW -: CW];
   assign rsp_corner3_y  = out_ff[RSW-1-7*CW -: CW];
   assign rsp_degenerate = out_ff[0];

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register holds a result while the output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall && e_v_ff))
      else $error("skid register filled without a stalled output and a pending result");

   a_degen_corners: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_corner0_x == rsp_corner1_x && rsp_corner0_y == rsp_corner1_y &&
         rsp_corner2_x == rsp_corner3_x && rsp_corner2_y == rsp_corner3_y)
      else $error("zero length segment produced nonzero offsets");
`endif

endmodule
`default_nettype wire

[rtl/lqe_front.sv]
// front stages: deltas, magnitudes, range shift, products and squared length
`default_nettype none
module lqe_front #(
   parameter int CW = 16,
   parameter int MW = 16,
   parameter int NW = 48
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [CW-1:0]            start_x,
   input  logic signed [CW-1:0]            start_y,
   input  logic signed [CW-1:0]            end_x,
   input  logic signed [CW-1:0]            end_y,
   input  logic [lqe_pkg::W_BITS-1:0]      line_width,
   output logic                            out_valid,
   output logic [NW-1:0]                   sq_sum,
   output logic [MW+lqe_pkg::W_BITS-1:0]   aw,
   output logic [MW+lqe_pkg::W_BITS-1:0]   bw,
   output lqe_pkg::seg_flags_type          flags,
   output logic [4*CW-1:0]                 pts
);
   import lqe_pkg::*;

   localparam int DW  = CW + 1;
   localparam int PW  = MW + W_BITS;
   localparam int SHW = $clog2(CW - MW + 2);

   logic               vld_ff [5];
   logic [4*CW-1:0]    pts_ff [5];
   logic [W_BITS-1:0]  w_ff [3];
   seg_flags_type      fl_ff [4];
   seg_flags_type      fl_in;
   logic [DW-1:0]      dx_ff;
   logic [DW-1:0]      dy_ff;
   logic [DW-1:0]      dx_abs;
   logic [DW-1:0]      dy_abs;
   logic [CW-1:0]      ab_or;
   logic [SHW-1:0]     sh_in;
   logic [SHW-1:0]     sh_ff;
   logic [CW-1:0]      am_ff;
   logic [CW-1:0]      bm_ff;
   logic [MW-1:0]      an_ff;
   logic [MW-1:0]      bn_ff;
   logic [2*MW-1:0]    aa_ff;
   logic [2*MW-1:0]    bb_ff;
   logic [PW-1:0]      aw4_ff;
   logic [PW-1:0]      bw4_ff;
   logic [PW-1:0]      aw5_ff;
   logic [PW-1:0]      bw5_ff;
   logic [2*MW:0]      sq_sum_w;
   logic [NW-1:0]      sum_ff;

   always_comb begin
      dx_abs = dx_ff[DW-1] ? (~dx_ff + 1'b1) : dx_ff;
      dy_abs = dy_ff[DW-1] ? (~dy_ff + 1'b1) : dy_ff;
      ab_or  = dx_abs[CW-1:0] | dy_abs[CW-1:0];
      // smallest common right shift that brings both magnitudes into range
      sh_in  = '0;
      for (int i = MW; i < CW; i++) begin
         if (ab_or[i]) begin
            sh_in = SHW'(i - MW + 1);
         end
      end
      fl_in.degen  = (dx_ff == '0) && (dy_ff == '0);
      fl_in.neg_dx = dx_ff[DW-1];
      fl_in.neg_dy = dy_ff[DW-1];
      sq_sum_w     = {1'b0, aa_ff} + {1'b0, bb_ff};
   end

   for (genvar s = 0; s < 5; s++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff     <= {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
         dy_ff     <= {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
         pts_ff[0] <= {start_x, start_y, end_x, end_y};
         w_ff[0]   <= line_width;

         am_ff     <= dx_abs[CW-1:0];
         bm_ff     <= dy_abs[CW-1:0];
         sh_ff     <= sh_in;
         fl_ff[0]  <= fl_in;
         pts_ff[1] <= pts_ff[0];
         w_ff[1]   <= w_ff[0];

         an_ff     <= MW'(am_ff >> sh_ff);
         bn_ff     <= MW'(bm_ff >> sh_ff);
         fl_ff[1]  <= fl_ff[0];
         pts_ff[2] <= pts_ff[1];
         w_ff[2]   <= w_ff[1];

         aa_ff     <= {{MW{1'b0}}, an_ff} * {{MW{1'b0}}, an_ff};
         bb_ff     <= {{MW{1'b0}}, bn_ff} * {{MW{1'b0}}, bn_ff};
         aw4_ff    <= {{W_BITS{1'b0}}, an_ff} * {{MW{1'b0}}, w_ff[2]};
         bw4_ff    <= {{W_BITS{1'b0}}, bn_ff} * {{MW{1'b0}}, w_ff[2]};
         fl_ff[2]  <= fl_ff[1];
         pts_ff[3] <= pts_ff[2];

         sum_ff    <= NW'({sq_sum_w, {SQ_SHIFT{1'b0}}});
         aw5_ff    <= aw4_ff;
         bw5_ff    <= bw4_ff;
         fl_ff[3]  <= fl_ff[2];
         pts_ff[4] <= pts_ff[3];
      end
   end

   assign out_valid = vld_ff[4];
   assign sq_sum    = sum_ff;
   assign aw        = aw5_ff;
   assign bw        = bw5_ff;
   assign flags     = fl_ff[3];
   assign pts       = pts_ff[4];

endmodule
`default_nettype wire

[rtl/lqe_sqrt.sv]
// pipelined integer square root, one root bit per stage
`default_nettype none
module lqe_sqrt #(
   parameter int NW = 48,
   parameter int TW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NW-1:0]     radicand,
   input  logic [TW-1:0]     in_tag,
   output logic              out_valid,
   output logic [NW/2-1:0]   root,
   output logic [TW-1:0]     out_tag
);

   localparam int R  = NW / 2;
   localparam int RW = R + 2;

   logic           vld_ff  [R];
   logic [NW-1:0]  rad_ff  [R];
   logic [RW-1:0]  rem_ff  [R];
   logic [R-1:0]   root_ff [R];
   logic [TW-1:0]  tag_ff  [R];

   for (genvar k = 0; k < R; k++) begin : g_stage
      logic           v_cur;
      logic [NW-1:0]  rad_cur;
      logic [RW-1:0]  rem_cur;
      logic [R-1:0]   root_cur;
      logic [TW-1:0]  tag_cur;
      logic [RW+1:0]  trial_rem;
      logic [RW+1:0]  trial_sub;
      logic           ge;

      if (k == 0) begin : g_first
         assign v_cur    = in_valid;
         assign rad_cur  = radicand;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign tag_cur  = in_tag;
      end else begin : g_next
         assign v_cur    = vld_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign tag_cur  = tag_ff[k-1];
      end

      always_comb begin
         // bring down the next bit pair, try 4q+1
         trial_rem = {rem_cur, rad_cur[NW-1-2*k -: 2]};
         trial_sub = {2'b00, root_cur, 2'b01};
         ge        = trial_rem >= trial_sub;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_cur;
            rem_ff[k]  <= ge ? RW'(trial_rem - trial_sub) : RW'(trial_rem);
            root_ff[k] <= {root_cur[R-2:0], ge};
            tag_ff[k]  <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[R-1];
   assign root      = root_ff[R-1];
   assign out_tag   = tag_ff[R-1];

endmodule
`default_nettype wire

[rtl/lqe_div.sv]
// pipelined two-lane restoring divider for the rounded offset magnitudes
`default_nettype none
module lqe_div #(
   parameter int PW  = 28,
   parameter int DVW = 24,
   parameter int TW  = 67
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [DVW-1:0]                divisor,
   input  logic [PW-1:0]                 prod_x,
   input  logic [PW-1:0]                 prod_y,
   input  logic [TW-1:0]                 in_tag,
   output logic                          out_valid,
   output logic [lqe_pkg::Q_BITS-1:0]    quot_x,
   output logic [lqe_pkg::Q_BITS-1:0]    quot_y,
   output logic [TW-1:0]                 out_tag
);
   import lqe_pkg::*;

   localparam int NUMW = PW + RND_SHIFT + 1;
   localparam int EW   = NUMW + Q_BITS;

   logic              pv_ff;
   logic [DVW-1:0]    pdvs_ff;
   logic [NUMW-1:0]   pnum_ff [2];
   logic [TW-1:0]     ptag_ff;

   logic              vld_ff [Q_BITS];
   logic [DVW-1:0]    dvs_ff [Q_BITS];
   logic [NUMW-1:0]   rem_ff [Q_BITS][2];
   logic [Q_BITS-1:0] quo_ff [Q_BITS][2];
   logic [TW-1:0]     tag_ff [Q_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= in_valid;
      end
   end

   // dividend = product * 64 + floor(len / 2), giving round half up
   always_ff @(posedge clock) begin
      if (en) begin
         pdvs_ff    <= divisor;
         pnum_ff[0] <= NUMW'({prod_x, {RND_SHIFT{1'b0}}}) + NUMW'(divisor >> 1);
         pnum_ff[1] <= NUMW'({prod_y, {RND_SHIFT{1'b0}}}) + NUMW'(divisor >> 1);
         ptag_ff    <= in_tag;
      end
   end

   for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
      logic              v_cur;
      logic [DVW-1:0]    dvs_cur;
      logic [NUMW-1:0]   rem_cur [2];
      logic [Q_BITS-1:0] quo_cur [2];
      logic [TW-1:0]     tag_cur;
      logic [EW-1:0]     dsh;
      logic              ge [2];
      logic [NUMW-1:0]   rem_nx [2];

      if (j == 0) begin : g_first
         assign v_cur   = pv_ff;
         assign dvs_cur = pdvs_ff;
         assign rem_cur = pnum_ff;
         assign quo_cur = '{default: '0};
         assign tag_cur = ptag_ff;
      end else begin : g_next
         assign v_cur   = vld_ff[j-1];
         assign dvs_cur = dvs_ff[j-1];
         assign rem_cur = rem_ff[j-1];
         assign quo_cur = quo_ff[j-1];
         assign tag_cur = tag_ff[j-1];
      end

      always_comb begin
         dsh = EW'(dvs_cur) << (Q_BITS - 1 - j);
         for (int l = 0; l < 2; l++) begin
            ge[l]     = EW'(rem_cur[l]) >= dsh;
            rem_nx[l] = ge[l] ? NUMW'(EW'(rem_cur[l]) - dsh) : rem_cur[l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvs_ff[j] <= dvs_cur;
            tag_ff[j] <= tag_cur;
            for (int l = 0; l < 2; l++) begin
               rem_ff[j][l] <= rem_nx[l];
               quo_ff[j][l] <= {quo_cur[l][Q_BITS-2:0], ge[l]};
            end
         end
      end
   end

   assign out_valid = vld_ff[Q_BITS-1];
   assign quot_x    = quo_ff[Q_BITS-1][0];
   assign quot_y    = quo_ff[Q_BITS-1][1];
   assign out_tag   = tag_ff[Q_BITS-1];

endmodule
`default_nettype wire

[tb/sv/line_to_quad_expansion_unit_tb.sv]
// testbench for the line to quad expansion unit: directed and random segments checked against a predictor
`default_nettype none
module line_to_quad_expansion_unit_tb;

   localparam int CB = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 1530;

   typedef struct packed {
      logic signed [CB-1:0] sx, sy, ex, ey;
      logic [lqe_pkg::W_BITS-1:0] w;
   } seg_t;

   typedef struct packed {
      logic signed [CB-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
      logic degen;
   } quad_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [CB-1:0] req_start_x = 0, req_start_y = 0, req_end_x = 0, req_end_y = 0;
   logic [lqe_pkg::W_BITS-1:0] req_line_width = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [CB-1:0] rsp_corner0_x, rsp_corner0_y, rsp_corner1_x, rsp_corner1_y;
   logic signed [CB-1:0] rsp_corner2_x, rsp_corner2_y, rsp_corner3_x, rsp_corner3_y;
   logic rsp_degenerate;

   line_to_quad_expansion_unit #(.COORD_BITS(CB)) dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   seg_t pending_segs[$];
   quad_t expected_quads[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit stim_done = 0;
   int req_gap = 0;
   int rsp_gap = 0;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [CB-1:0] clamp_coord(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[CB-1:0];
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic quad_t expand_segment(seg_t s);
      quad_t q;
      longint sx, sy, ex, ey, dx, dy, xd, yd;
      longint unsigned a, b, len, qx, qy, w;
      sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey; w = s.w;
      dx = ex - sx; dy = ey - sy;
      xd = 0; yd = 0;
      q.degen = (dx == 0 && dy == 0);
      if (!q.degen) begin
         a = dx < 0 ? -dx : dx;
         b = dy < 0 ? -dy : dy;
         while (a >= (64'd1 << lqe_pkg::LIM_BITS) || b >= (64'd1 << lqe_pkg::LIM_BITS)) begin
            a >>= 1;
            b >>= 1;
         end
         len = root64((a * a + b * b) << lqe_pkg::SQ_SHIFT);
         if (len == 0) len = 1;
         qx = (b * w * 64 + (len >> 1)) / len;
         qy = (a * w * 64 + (len >> 1)) / len;
         xd = dy < 0 ? -longint'(qx) : longint'(qx);
         yd = dx < 0 ? -longint'(qy) : longint'(qy);
      end
      q.c0x = clamp_coord(sx + xd); q.c0y = clamp_coord(sy - yd);
      q.c1x = clamp_coord(sx - xd); q.c1y = clamp_coord(sy + yd);
      q.c2x = clamp_coord(ex - xd); q.c2y = clamp_coord(ey + yd);
      q.c3x = clamp_coord(ex + xd); q.c3y = clamp_coord(ey - yd);
      return q;
   endfunction

   function automatic logic [CB-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return CB'($urandom_range(0, 64) - 32);
         default: return CB'($urandom);
      endcase
   endfunction

   task automatic add_seg(logic [CB-1:0] sx, sy, ex, ey, logic [11:0] w);
      seg_t s;
      s = '{sx, sy, ex, ey, w};
      pending_segs.push_back(s);
   endtask

   // driver
   always @(posedge clock) begin
      int g;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_quads.push_back(expand_segment(
               '{req_start_x, req_start_y, req_end_x, req_end_y, req_line_width}));
            void'(pending_segs.pop_front());
            g = gap_len();
            // no gap: the next segment follows in the very next cycle
            if (g == 0 && pending_segs.size() > 0) begin
               req_start_x <= pending_segs[0].sx;
               req_start_y <= pending_segs[0].sy;
               req_end_x <= pending_segs[0].ex;
               req_end_y <= pending_segs[0].ey;
               req_line_width <= pending_segs[0].w;
            end else begin
               req_gap <= g;
               req_valid <= 0;
            end
         end else if (!req_valid) begin
            if (req_gap > 0) req_gap <= req_gap - 1;
            else if (pending_segs.size() > 0) begin
               req_valid <= 1;
               req_start_x <= pending_segs[0].sx;
               req_start_y <= pending_segs[0].sy;
               req_end_x <= pending_segs[0].ex;
               req_end_y <= pending_segs[0].ey;
               req_line_width <= pending_segs[0].w;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      quad_t got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_corner0_x, rsp_corner0_y, rsp_corner1_x, rsp_corner1_y,
                    rsp_corner2_x, rsp_corner2_y, rsp_corner3_x, rsp_corner3_y,
                    rsp_degenerate};
            if (expected_quads.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer: %p", got);
            end else begin
               want = expected_quads.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_stall <= 1;
            rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_stall <= 0;
            rsp_gap <= gap_len();
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int mode;
      logic [CB-1:0] x, y;
      // directed: extremes, zero length, axis aligned, diagonal, saturation
      add_seg(0, 0, 0, 0, 12'hfff);
      add_seg(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      add_seg(0, 0, 16, 0, 32);
      add_seg(0, 0, 0, 16, 32);
      add_seg(0, 0, -16, 0, 32);
      add_seg(0, 0, 0, -16, 32);
      add_seg(0, 0, 48, 64, 12'hfff);
      add_seg(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 12'hfff);
      add_seg(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 12'hfff);
      add_seg(16'h7fff, 16'h7fff, 16'h7ff0, 16'h7fff, 12'hfff);
      add_seg(16'h8000, 0, 16'h8000, 100, 12'hfff);
      add_seg(0, 0, 1, 1, 12'hfff);
      add_seg(0, 0, 1, 0, 1);
      add_seg(5, 5, 5, 5, 0);
      add_seg(16'hffff, 16'hffff, 16'h5555, 16'haaaa, 12'h555);
      add_seg(16'h5555, 16'haaaa, 16'hffff, 0, 12'haaa);
      repeat (N_RANDOM) begin
         mode = $urandom_range(0, 9);
         x = rand_coord();
         y = rand_coord();
         if (mode == 0) add_seg(x, y, x, y, 12'($urandom));
         else if (mode < 3)
            add_seg(x, y, CB'(x + $urandom_range(0, 6) - 3),
                    CB'(y + $urandom_range(0, 6) - 3), 12'($urandom));
         else add_seg(x, y, rand_coord(), rand_coord(), 12'($urandom));
      end
      repeat (10) @(posedge clock);
      reset <= 0;
      wait (pending_segs.size() == 0 && !req_valid);
      wait (expected_quads.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_quads.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire
